// File: rtl/cursor_linked_list_editor_assert.svh
// Assertion macros used by the checker file of the list editor.
`ifndef CURSOR_LINKED_LIST_EDITOR_ASSERT_SVH
`define CURSOR_LINKED_LIST_EDITOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CLLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clle assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define CLLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clle assertion failed");

`endif

// File: rtl/clle_pkg.sv
// Shared constants and types of the cursor linked list editor.
package clle_pkg;

  localparam int unsigned POOL_NODES_DEF = 1024;
  localparam int unsigned MODE_W         = 3;
  localparam int unsigned VALUE_W        = 32;
  localparam int unsigned START_W        = 10;

  typedef logic [MODE_W-1:0]         mode_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [START_W-1:0]        start_t;

  localparam start_t START_RESET = start_t'(1);

  localparam mode_t MODE_APPEND    = 3'd0;
  localparam mode_t MODE_MOVE_LEFT = 3'd1;
  localparam mode_t MODE_MOVE_RIGHT = 3'd2;
  localparam mode_t MODE_READ      = 3'd3;
  localparam mode_t MODE_INS_RIGHT = 3'd4;
  localparam mode_t MODE_INS_LEFT  = 3'd5;

endpackage

// File: rtl/clle_in_if.sv
// Request channel of the list editor: valid/ready with mode and value.
interface clle_in_if;
  logic              valid;
  logic              ready;
  clle_pkg::mode_t   mode;
  clle_pkg::value_t  value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// File: rtl/clle_out_if.sv
// Response channel of the list editor: valid/ready with value and drop flag.
interface clle_out_if;
  logic              valid;
  logic              ready;
  clle_pkg::value_t  value_out;
  logic              dropped;

  modport source (output valid, output value_out, output dropped, input ready);
  modport sink   (input valid, input value_out, input dropped, output ready);
endinterface

// File: rtl/clle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/cursor_linked_list_editor.sv
// Top level: doubly linked list in a node pool with an editing cursor.
//
//  channel | dir | handshake          | payload
//  in_req  | in  | valid / ready      | mode[2:0], value[31:0] signed
//  out_rsp | out | valid / ready      | value_out[31:0] signed, dropped
//  cfg     | in  | cfg_we, no wait    | cfg_wdata[9:0] start position
//
// Move, read and ignored requests pass the idle and execute states; a
// successful append or insert adds a link state (node fill, then relink
// of its neighbors), due to the registered read and single write port of
// the node RAMs. A response waiting on out_rsp stalls the block only
// when the next response is ready to load. Synchronous active-low reset;
// no clearing pass, node 0 (head sentinel) is served from registers.
module cursor_linked_list_editor #(
  parameter int unsigned POOL_NODES = clle_pkg::POOL_NODES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  clle_in_if.sink                  in_req,
  clle_out_if.source               out_rsp,
  input  logic                     cfg_we,
  input  logic [clle_pkg::START_W-1:0] cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(POOL_NODES);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned CMP_W  = (CNT_W > clle_pkg::START_W) ? CNT_W : clle_pkg::START_W;
  localparam logic [ADDR_W-1:0] NIL       = '0;
  localparam logic [ADDR_W-1:0] LAST_FREE = ADDR_W'(POOL_NODES - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(POOL_NODES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_LINK = 3'b100
  } state_t;

  typedef logic [ADDR_W-1:0] node_t;

  state_t                         state_r, state_nxt;
  clle_pkg::mode_t                mode_r, mode_nxt;
  logic [clle_pkg::VALUE_W-1:0]   value_r, value_nxt;
  node_t                          addr_r, addr_nxt;
  node_t                          cursor_r, cursor_nxt;
  node_t                          tail_r, tail_nxt;
  node_t                          head_r, head_nxt;
  node_t                          used_r, used_nxt;
  logic [CNT_W-1:0]               appended_r, appended_nxt;
  clle_pkg::start_t               start_r, start_nxt;
  node_t                          fresh_r, fresh_nxt;
  node_t                          lnk_next_addr_r, lnk_next_addr_nxt;
  node_t                          lnk_prev_addr_r, lnk_prev_addr_nxt;
  logic                           lnk_prev_en_r, lnk_prev_en_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [clle_pkg::VALUE_W-1:0]   out_value_r, out_value_nxt;
  logic                           out_dropped_r, out_dropped_nxt;

  logic                           val_we;
  node_t                          val_waddr;
  logic [clle_pkg::VALUE_W-1:0]   val_rdata;
  logic                           nxt_we, prv_we;
  node_t                          nxt_waddr, nxt_wdata, nxt_rdata;
  node_t                          prv_waddr, prv_wdata, prv_rdata;
  node_t                          rd_addr;

  logic                           in_acc;
  node_t                          node_next, node_prev, fresh;
  logic [clle_pkg::VALUE_W-1:0]   node_val;
  logic [CNT_W-1:0]               app_inc;
  logic                           full, is_ins, drop, do_ins, has_rsp, exec_go;

  assign in_req.ready      = (state_r == ST_IDLE);
  assign in_acc            = in_req.valid && in_req.ready;
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.value_out = out_value_r;
  assign out_rsp.dropped   = out_dropped_r;

  // Appends work at the tail, everything else at the cursor.
  assign rd_addr = (state_r != ST_IDLE) ? addr_r :
                   (in_req.mode == clle_pkg::MODE_APPEND) ? tail_r : cursor_r;

  clle_ram #(.WIDTH(clle_pkg::VALUE_W), .DEPTH(POOL_NODES)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(value_r),
    .raddr(rd_addr), .rdata(val_rdata)
  );

  clle_ram #(.WIDTH(ADDR_W), .DEPTH(POOL_NODES)) u_next_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(rd_addr), .rdata(nxt_rdata)
  );

  clle_ram #(.WIDTH(ADDR_W), .DEPTH(POOL_NODES)) u_prev_ram (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(rd_addr), .rdata(prv_rdata)
  );

  // Sentinel: value zero, next link kept in head_r.
  assign node_next = (addr_r == NIL) ? head_r : nxt_rdata;
  assign node_prev = prv_rdata;
  assign node_val  = (addr_r == NIL) ? '0 : val_rdata;
  assign fresh     = used_r + 1'b1;
  assign full      = (used_r == LAST_FREE);
  assign app_inc   = (appended_r < CNT_MAX) ? appended_r + 1'b1 : appended_r;

  assign is_ins  = (mode_r == clle_pkg::MODE_APPEND) || (mode_r == clle_pkg::MODE_INS_RIGHT) ||
                   ((mode_r == clle_pkg::MODE_INS_LEFT) && (addr_r != NIL));
  assign drop    = is_ins && full;
  assign do_ins  = is_ins && !full;
  assign has_rsp = drop || (mode_r == clle_pkg::MODE_READ);
  assign exec_go = (state_r == ST_EXEC) && (!has_rsp || !out_valid_r || out_rsp.ready);

  always_comb begin
    state_nxt         = state_r;
    mode_nxt          = mode_r;
    value_nxt         = value_r;
    addr_nxt          = addr_r;
    cursor_nxt        = cursor_r;
    tail_nxt          = tail_r;
    head_nxt          = head_r;
    used_nxt          = used_r;
    appended_nxt      = appended_r;
    start_nxt         = start_r;
    fresh_nxt         = fresh_r;
    lnk_next_addr_nxt = lnk_next_addr_r;
    lnk_prev_addr_nxt = lnk_prev_addr_r;
    lnk_prev_en_nxt   = lnk_prev_en_r;
    out_valid_nxt     = out_valid_r;
    out_value_nxt     = out_value_r;
    out_dropped_nxt   = out_dropped_r;
    val_we            = 1'b0;
    val_waddr         = fresh;
    nxt_we            = 1'b0;
    nxt_waddr         = fresh;
    nxt_wdata         = node_next;
    prv_we            = 1'b0;
    prv_waddr         = fresh;
    prv_wdata         = addr_r;

    if (cfg_we) begin
      start_nxt = cfg_wdata;
    end

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
          mode_nxt  = in_req.mode;
          value_nxt = in_req.value;
          addr_nxt  = rd_addr;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_nxt = ST_IDLE;
          if (has_rsp) begin
            out_valid_nxt   = 1'b1;
            out_value_nxt   = drop ? '0 : node_val;
            out_dropped_nxt = drop;
          end
          if (do_ins) begin
            state_nxt = ST_LINK;
            used_nxt  = fresh;
            fresh_nxt = fresh;
            val_we    = 1'b1;
            nxt_we    = 1'b1;
            prv_we    = 1'b1;
            if (mode_r == clle_pkg::MODE_INS_LEFT) begin
              nxt_wdata         = addr_r;
              prv_wdata         = node_prev;
              lnk_next_addr_nxt = node_prev;
              lnk_prev_addr_nxt = addr_r;
              lnk_prev_en_nxt   = 1'b1;
            end else begin
              lnk_next_addr_nxt = addr_r;
              lnk_prev_addr_nxt = node_next;
              lnk_prev_en_nxt   = (node_next != NIL);
              if (addr_r == tail_r) begin
                tail_nxt = fresh;
              end
              if (mode_r == clle_pkg::MODE_APPEND) begin
                appended_nxt = app_inc;
                if (CMP_W'(app_inc) == CMP_W'(start_r)) begin
                  cursor_nxt = fresh;
                end
              end
            end
          end else if (mode_r == clle_pkg::MODE_MOVE_LEFT) begin
            if ((addr_r != NIL) && (node_prev != NIL)) begin
              cursor_nxt = node_prev;
            end
          end else if (mode_r == clle_pkg::MODE_MOVE_RIGHT) begin
            if (node_next != NIL) begin
              cursor_nxt = node_next;
            end
          end
        end
      end
      ST_LINK: begin
        state_nxt = ST_IDLE;
        nxt_waddr = lnk_next_addr_r;
        nxt_wdata = fresh_r;
        nxt_we    = (lnk_next_addr_r != NIL);
        if (lnk_next_addr_r == NIL) begin
          head_nxt = fresh_r;
        end
        prv_waddr = lnk_prev_addr_r;
        prv_wdata = fresh_r;
        prv_we    = lnk_prev_en_r;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= NIL;
      tail_r      <= NIL;
      head_r      <= NIL;
      used_r      <= NIL;
      appended_r  <= '0;
      start_r     <= clle_pkg::START_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      tail_r      <= tail_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      appended_r  <= appended_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r          <= mode_nxt;
    value_r         <= value_nxt;
    addr_r          <= addr_nxt;
    fresh_r         <= fresh_nxt;
    lnk_next_addr_r <= lnk_next_addr_nxt;
    lnk_prev_addr_r <= lnk_prev_addr_nxt;
    lnk_prev_en_r   <= lnk_prev_en_nxt;
    out_value_r     <= out_value_nxt;
    out_dropped_r   <= out_dropped_nxt;
  end

endmodule

// File: rtl/clle_checker.sv
// Port-level assertions for the list editor, bound to the top level.
`include "cursor_linked_list_editor_assert.svh"

module clle_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input clle_pkg::value_t out_value_out,
  input logic             out_dropped
);

  `CLLE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value_out) && $stable(out_dropped))
  `CLLE_ASSERT_NXT(a_one_request, in_valid && in_ready, !in_ready)
  `CLLE_ASSERT_IMP(a_rsp_after_work, $rose(out_valid), !$past(in_ready))
  `CLLE_ASSERT_IMP(a_drop_zero, out_valid && out_dropped, out_value_out == '0)

endmodule

bind cursor_linked_list_editor clle_checker u_clle_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .out_value_out(out_rsp.value_out),
  .out_dropped  (out_rsp.dropped)
);

// File: dv/cursor_linked_list_editor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the cursor linked list editor with its own list predictor.
module cursor_linked_list_editor_tb;

  localparam int unsigned POOL = clle_pkg::POOL_NODES_DEF;
  localparam clle_pkg::mode_t MODE_SPARE_6 = 3'd6;
  localparam clle_pkg::mode_t MODE_SPARE_7 = 3'd7;
  localparam clle_pkg::value_t VALUE_MIN = 32'sh8000_0000;
  localparam clle_pkg::value_t VALUE_MAX = 32'sh7FFF_FFFF;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_REQUESTS = 270;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    clle_pkg::mode_t  mode;
    clle_pkg::value_t value;
  } edit_request_t;

  typedef struct packed {
    clle_pkg::value_t value_out;
    logic             dropped;
  } edit_response_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  clle_pkg::start_t cfg_wdata;

  clle_in_if  req_if ();
  clle_out_if rsp_if ();

  cursor_linked_list_editor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_if),
    .out_rsp   (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // list predictor state
  clle_pkg::value_t node_value [POOL];
  int unsigned      node_next [POOL];
  int unsigned      node_prev [POOL];
  int unsigned      used_count;
  int unsigned      cur_idx;
  int unsigned      last_idx;
  int unsigned      append_total;
  clle_pkg::start_t start_pos;

  edit_request_t  request_queue [$];
  edit_response_t awaited_responses [$];
  edit_response_t oldest;
  edit_request_t  next_req;

  bit          req_hold;
  bit          req_taken;
  int unsigned req_gap;
  int unsigned rsp_wait;
  bit          no_idle;
  int unsigned error_count;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic queue_response(input edit_response_t rsp);
    awaited_responses.insert(awaited_responses.size(), rsp);
  endtask

  function automatic int unsigned grab_node(input clle_pkg::value_t v);
    if (used_count >= POOL - 1) return 0;
    used_count++;
    node_value[used_count] = v;
    node_next[used_count] = 0;
    node_prev[used_count] = 0;
    return used_count;
  endfunction

  function automatic void splice_after(input int unsigned at, input int unsigned fresh);
    int unsigned after;
    after = node_next[at];
    node_prev[fresh] = at;
    node_next[fresh] = after;
    node_next[at] = fresh;
    if (after != 0) node_prev[after] = fresh;
    if (at == last_idx) last_idx = fresh;
  endfunction

  task automatic edit_list(input clle_pkg::mode_t m, input clle_pkg::value_t v);
    int unsigned fresh;
    int unsigned left_idx;
    edit_response_t rsp;
    fresh = 0;
    rsp.value_out = '0;
    rsp.dropped = 1'b1;
    case (m)
      clle_pkg::MODE_APPEND: begin
        fresh = grab_node(v);
        if (fresh != 0) begin
          splice_after(last_idx, fresh);
          if (append_total < POOL) append_total++;
          if (append_total == start_pos) cur_idx = fresh;
        end else begin
          queue_response(rsp);
        end
      end
      clle_pkg::MODE_MOVE_LEFT: begin
        if (cur_idx != 0 && node_prev[cur_idx] != 0) cur_idx = node_prev[cur_idx];
      end
      clle_pkg::MODE_MOVE_RIGHT: begin
        if (node_next[cur_idx] != 0) cur_idx = node_next[cur_idx];
      end
      clle_pkg::MODE_READ: begin
        rsp.value_out = node_value[cur_idx];
        rsp.dropped = 1'b0;
        queue_response(rsp);
      end
      clle_pkg::MODE_INS_RIGHT: begin
        fresh = grab_node(v);
        if (fresh != 0) splice_after(cur_idx, fresh);
        else queue_response(rsp);
      end
      clle_pkg::MODE_INS_LEFT: begin
        if (cur_idx != 0) begin
          fresh = grab_node(v);
          if (fresh != 0) begin
            left_idx = node_prev[cur_idx];
            node_prev[fresh] = left_idx;
            node_next[fresh] = cur_idx;
            node_prev[cur_idx] = fresh;
            node_next[left_idx] = fresh;
          end else begin
            queue_response(rsp);
          end
        end
      end
      default: ;
    endcase
  endtask

  // sampling of both channels and the register port
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) start_pos = cfg_wdata;
      if (req_if.valid && req_if.ready) begin
        edit_list(req_if.mode, req_if.value);
        req_taken = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_wait = no_idle ? 0 : $urandom_range(0, 15);
        if (awaited_responses.size() == 0) begin
          report_mismatch($sformatf("unexpected response value %0d dropped %0b",
                                    rsp_if.value_out, rsp_if.dropped));
        end else begin
          oldest = awaited_responses.pop_front();
          if (rsp_if.value_out !== oldest.value_out)
            report_mismatch($sformatf("value_out %0d, expected %0d",
                                      rsp_if.value_out, oldest.value_out));
          if (rsp_if.dropped !== oldest.dropped)
            report_mismatch($sformatf("dropped %0b, expected %0b",
                                      rsp_if.dropped, oldest.dropped));
        end
      end
    end
  end

  // request driver and response back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (req_hold && req_taken) begin
        req_hold = 1'b0;
        req_gap = no_idle ? 0 : $urandom_range(0, 15);
      end
      req_taken = 1'b0;
      if (!req_hold) begin
        if (req_gap != 0) begin
          req_gap--;
        end else if (request_queue.size() != 0) begin
          next_req = request_queue.pop_front();
          req_if.mode <= next_req.mode;
          req_if.value <= next_req.value;
          req_hold = 1'b1;
        end
      end
      req_if.valid <= req_hold;
      if (rsp_if.valid && rsp_wait != 0) rsp_wait--;
      rsp_if.ready <= (rsp_wait == 0);
    end
  end

  task automatic push_request(input clle_pkg::mode_t m, input clle_pkg::value_t v);
    edit_request_t r;
    r.mode = m;
    r.value = v;
    request_queue.insert(request_queue.size(), r);
  endtask

  task automatic wait_idle();
    while (request_queue.size() != 0 || req_hold) @(posedge clk);
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(input clle_pkg::start_t pos);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= pos;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned      want;
    int unsigned      pick;
    clle_pkg::mode_t  m;
    clle_pkg::value_t v;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.mode = clle_pkg::MODE_APPEND;
    req_if.value = '0;
    rsp_if.ready = 1'b0;
    foreach (node_value[i]) begin
      node_value[i] = '0;
      node_next[i] = 0;
      node_prev[i] = 0;
    end
    used_count = 0;
    cur_idx = 0;
    last_idx = 0;
    append_total = 0;
    start_pos = clle_pkg::START_RESET;
    req_hold = 1'b0;
    req_taken = 1'b0;
    req_gap = 0;
    rsp_wait = 0;
    no_idle = 1'b0;
    error_count = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty list, cursor on head, list ends, tail insert
    write_start(clle_pkg::start_t'(3));
    push_request(clle_pkg::MODE_READ, '0);
    push_request(clle_pkg::MODE_MOVE_LEFT, '0);
    push_request(clle_pkg::MODE_MOVE_RIGHT, '0);
    push_request(clle_pkg::MODE_INS_LEFT, 32'sd5);
    push_request(MODE_SPARE_6, VALUE_MAX);
    push_request(MODE_SPARE_7, VALUE_MIN);
    push_request(clle_pkg::MODE_INS_RIGHT, VALUE_MAX);
    push_request(clle_pkg::MODE_READ, '0);
    push_request(clle_pkg::MODE_MOVE_RIGHT, '0);
    push_request(clle_pkg::MODE_READ, '0);
    push_request(clle_pkg::MODE_MOVE_LEFT, '0);
    push_request(clle_pkg::MODE_APPEND, VALUE_MIN);
    push_request(clle_pkg::MODE_APPEND, '0);
    push_request(clle_pkg::MODE_APPEND, -32'sd1);
    push_request(clle_pkg::MODE_READ, '0);
    push_request(clle_pkg::MODE_MOVE_RIGHT, '0);
    push_request(clle_pkg::MODE_INS_RIGHT, 32'sh5555_5555);
    push_request(clle_pkg::MODE_APPEND, 32'sh2AAA_AAAA);
    push_request(clle_pkg::MODE_INS_LEFT, 32'sh1234_5678);
    push_request(clle_pkg::MODE_MOVE_LEFT, '0);
    push_request(clle_pkg::MODE_READ, '0);
    push_request(clle_pkg::MODE_MOVE_RIGHT, '0);
    push_request(clle_pkg::MODE_MOVE_RIGHT, '0);
    push_request(clle_pkg::MODE_READ, '0);
    wait_idle();

    // random phases; adds dominate so the pool fills and drops follow
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: want = append_total + $urandom_range(1, 20);
        1: want = 1023;
        2: want = append_total + $urandom_range(1, 60);
        3: want = 0;
        4: want = 1;
        default: want = append_total + $urandom_range(1, 8);
      endcase
      if (want > 1023) want = 1023;
      write_start(clle_pkg::start_t'(want));
      no_idle = (p % 3 == 1);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) m = clle_pkg::MODE_APPEND;
        else if (pick < 58) m = clle_pkg::MODE_INS_RIGHT;
        else if (pick < 74) m = clle_pkg::MODE_INS_LEFT;
        else if (pick < 80) m = clle_pkg::MODE_MOVE_LEFT;
        else if (pick < 86) m = clle_pkg::MODE_MOVE_RIGHT;
        else if (pick < 97) m = clle_pkg::MODE_READ;
        else if (pick < 98) m = MODE_SPARE_6;
        else m = MODE_SPARE_7;
        case ($urandom_range(0, 11))
          0: v = VALUE_MIN;
          1: v = VALUE_MAX;
          2: v = '0;
          3: v = -32'sd1;
          default: v = $urandom;
        endcase
        push_request(m, v);
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("PASS cursor_linked_list_editor");
    end else begin
      $display("FAIL cursor_linked_list_editor");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL cursor_linked_list_editor");
    $finish;
  end

endmodule
